// ===== sv/fade_ramp_with_kick_in_curve_macros.svh =====
// assertion helpers for the fade ramp block
`ifndef FADE_RAMP_WITH_KICK_IN_CURVE_MACROS_SVH
`define FADE_RAMP_WITH_KICK_IN_CURVE_MACROS_SVH

// same-cycle implication, checked out of reset
`define FRKC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fade ramp: same-cycle check failed");

// next-cycle implication, checked out of reset
`define FRKC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fade ramp: next-cycle check failed");

`endif

// ===== sv/frkc_pkg.sv =====
`default_nettype none

package frkc_pkg;

	// level and time formats
	localparam int unsigned LEVEL_FRAC_BITS = 24;
	localparam int unsigned LEVEL_W         = LEVEL_FRAC_BITS + 1;
	localparam int unsigned RATE_W          = LEVEL_W + 1;
	localparam int unsigned TIME_W          = 16;
	localparam int unsigned KICK_W          = 16;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(1) << LEVEL_FRAC_BITS;
	localparam logic [TIME_W-1:0]  DEFAULT_LENGTH = TIME_W'(3000);

	// curve table
	localparam int unsigned CURVE_POINTS = 256;
	localparam int unsigned CURVE_IDX_W  = $clog2(CURVE_POINTS + 1);
	localparam int unsigned CURVE_SHIFT  = $clog2(CURVE_POINTS);

	// shared divider: 25-bit dividend, 16-bit divisor
	localparam int unsigned DIV_N_W   = LEVEL_W;
	localparam int unsigned DIV_D_W   = TIME_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W);

	// fixed-point constants used to build the curve table
	localparam int unsigned       QB      = 30;
	localparam longint unsigned   QONE    = 64'd1 << QB;
	localparam longint unsigned   PI_Q30  = 64'd3373259426;
	localparam longint unsigned   EXP_NUM = 64'd66;
	localparam longint unsigned   EXP_DEN = 64'd100;

	typedef logic [KICK_W-1:0] curve_rom_t [0:CURVE_POINTS];

	// floor square root, bit by bit
	function automatic longint unsigned isqrt64(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		longint unsigned vv;
		int j;
		r  = 64'd0;
		b  = 64'd1 << 62;
		vv = v;
		for (j = 0; j < 32; j++) begin
			if (b > vv) b = b >> 2;
		end
		for (j = 0; j < 32; j++) begin
			if (b != 64'd0) begin
				if (vv >= r + b) begin
					vv = vv - (r + b);
					r  = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// log2 in Q30 by repeated squaring, fraction truncated
	function automatic longint unsigned log2_q30(input longint unsigned v);
		int unsigned     n;
		longint unsigned m;
		longint unsigned frac;
		int              j;
		int              k;
		n    = 0;
		frac = 64'd0;
		for (j = 0; j < 30; j++) begin
			if ((v >> n) > 64'd1) n++;
		end
		m = v << (30 - n);
		for (k = 1; k <= 30; k++) begin
			m = (m * m) >> QB;
			if (m >= 2 * QONE) begin
				m    = m >> 1;
				frac = frac | (64'd1 << (QB - k));
			end
		end
		return (longint'(n) << QB) | frac;
	endfunction

	// sin^3(pi * x^0.66) for x = i / CURVE_POINTS, scaled to 65535
	function automatic logic [KICK_W-1:0] curve_value(input int unsigned i);
		longint unsigned lp, li, d, e, ip, fp, r, c, u, w, a, s, s3, outv, term;
		longint          sum;
		int              k;
		int              n;
		if (i == 0 || i > CURVE_POINTS) return '0;
		lp = log2_q30(64'(CURVE_POINTS));
		li = log2_q30(64'(i));
		d  = (lp > li) ? lp - li : 64'd0;
		e  = d * EXP_NUM / EXP_DEN;
		ip = e >> QB;
		fp = e & (QONE - 64'd1);
		r  = QONE;
		c  = QONE / 2;
		for (k = 1; k <= 30; k++) begin
			c = isqrt64(c << QB);
			if (((fp >> (QB - k)) & 64'd1) != 64'd0) r = (r * c) >> QB;
		end
		u = (ip >= 64'd63) ? 64'd0 : r >> ip;
		if (u > QONE) u = QONE;
		w    = (QONE - u < u) ? QONE - u : u;
		a    = (w * PI_Q30) >> QB;
		term = a;
		sum  = longint'(a);
		for (n = 1; n <= 7; n++) begin
			term = (term * a) >> QB;
			term = (term * a) >> QB;
			// factorial ratio (2n)(2n+1) of each taylor term
			case (n)
				1:       term = term / 64'd6;
				2:       term = term / 64'd20;
				3:       term = term / 64'd42;
				4:       term = term / 64'd72;
				5:       term = term / 64'd110;
				6:       term = term / 64'd156;
				default: term = term / 64'd210;
			endcase
			if ((n & 1) != 0) sum = sum - longint'(term);
			else              sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		s = longint'(sum);
		if (s > QONE) s = QONE;
		s3   = (((s * s) >> QB) * s) >> QB;
		outv = (s3 * 64'd65535 + QONE / 2) >> QB;
		return (outv > 64'd65535) ? {KICK_W{1'b1}} : outv[KICK_W-1:0];
	endfunction

	function automatic curve_rom_t build_curve_rom();
		curve_rom_t rom;
		int         idx;
		for (idx = 0; idx <= CURVE_POINTS; idx++) begin
			rom[CURVE_IDX_W'(idx)] = curve_value(idx);
		end
		return rom;
	endfunction

	localparam curve_rom_t CURVE_ROM = build_curve_rom();

endpackage

`default_nettype wire

// ===== sv/fade_ramp_with_kick_in_curve.sv =====
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | mode, delta_ms, fade_in, fade_length_ms
// out     | output    | out_valid / out_ready | fader_level, kick_in_level, fader_idle,
//         |           |                       | kick_in_idle
//
// one item at a time through a 25-step restoring divider shared by the rate and
// the curve index: a tick runs multiply, accumulate, curve setup and the index divide,
// a start the rate divide, curve setup and the index divide; an item whose kick-in timer
// ends up inactive skips the index divide
// arst_n clears control and state; fade length resets to 3000 ms
// a finished result waits in the output register; a stalled output only holds the
// block in its last step, the next item is taken once that result is loaded
`default_nettype none

`include "fade_ramp_with_kick_in_curve_macros.svh"

module fade_ramp_with_kick_in_curve (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          mode,
	input  wire logic [frkc_pkg::TIME_W-1:0]   delta_ms,
	input  wire logic                          fade_in,
	input  wire logic [frkc_pkg::TIME_W-1:0]   fade_length_ms,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [frkc_pkg::LEVEL_W-1:0]       fader_level,
	output logic [frkc_pkg::KICK_W-1:0]        kick_in_level,
	output logic                               fader_idle,
	output logic                               kick_in_idle
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RATE_DIV,
		ST_MUL,
		ST_ACC,
		ST_CURVE_SETUP,
		ST_CURVE_DIV,
		ST_DONE
	} state_t;

	localparam int unsigned PROD_W = frkc_pkg::RATE_W + frkc_pkg::TIME_W + 1;
	localparam int unsigned SUM_W  = PROD_W + 1;

	state_t                                 state_q;
	logic [frkc_pkg::LEVEL_W-1:0]           level_q;
	logic signed [frkc_pkg::RATE_W-1:0]     rate_q;
	logic [frkc_pkg::TIME_W-1:0]            kick_timer_q;
	logic                                   kick_active_q;
	logic [frkc_pkg::TIME_W-1:0]            fade_length_q;
	logic [frkc_pkg::TIME_W-1:0]            delta_q;
	logic                                   fin_q;
	logic signed [PROD_W-1:0]               prod_q;
	logic [frkc_pkg::CURVE_IDX_W-1:0]       kick_idx_q;

	logic [frkc_pkg::DIV_N_W-1:0]           div_quo_q;
	logic [frkc_pkg::DIV_D_W-1:0]           div_rem_q;
	logic [frkc_pkg::DIV_D_W-1:0]           div_dvs_q;
	logic [frkc_pkg::DIV_CNT_W-1:0]         div_cnt_q;

	logic                                   out_valid_q;
	logic [frkc_pkg::LEVEL_W-1:0]           fader_level_q;
	logic [frkc_pkg::KICK_W-1:0]            kick_in_level_q;
	logic                                   fader_idle_q;
	logic                                   kick_in_idle_q;

	// divider step: shift in one dividend bit, trial subtract
	logic [frkc_pkg::DIV_D_W:0]             rem_sh;
	logic                                   div_ge;
	logic [frkc_pkg::DIV_D_W:0]             rem_sub;
	logic [frkc_pkg::DIV_D_W-1:0]           rem_nx;
	logic [frkc_pkg::DIV_N_W-1:0]           quo_nx;
	logic                                   div_last;

	always_comb begin
		rem_sh   = {div_rem_q, div_quo_q[frkc_pkg::DIV_N_W-1]};
		div_ge   = rem_sh >= {1'b0, div_dvs_q};
		rem_sub  = rem_sh - {1'b0, div_dvs_q};
		rem_nx   = div_ge ? rem_sub[frkc_pkg::DIV_D_W-1:0] : rem_sh[frkc_pkg::DIV_D_W-1:0];
		quo_nx   = {div_quo_q[frkc_pkg::DIV_N_W-2:0], div_ge};
		div_last = div_cnt_q == frkc_pkg::DIV_CNT_W'(frkc_pkg::DIV_N_W - 1);
	end

	// start length, zero taken as one
	logic [frkc_pkg::TIME_W-1:0] len_eff;
	assign len_eff = (fade_length_ms == '0) ? frkc_pkg::TIME_W'(1) : fade_length_ms;

	// level update with clamping
	logic signed [SUM_W-1:0] level_sum;
	assign level_sum = $signed({{(SUM_W - frkc_pkg::LEVEL_W){1'b0}}, level_q})
		+ SUM_W'(prod_q);

	// timer advance
	logic [frkc_pkg::TIME_W:0] timer_sum;
	assign timer_sum = {1'b0, kick_timer_q} + {1'b0, delta_q};

	// timer clamped to the length for the curve index
	logic [frkc_pkg::TIME_W-1:0] timer_clamped;
	assign timer_clamped = (kick_timer_q > fade_length_q) ? fade_length_q : kick_timer_q;

	// signed rate from the quotient
	logic signed [frkc_pkg::RATE_W-1:0] rate_mag;
	assign rate_mag = $signed({1'b0, quo_nx});

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	// sequencer, state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			level_q       <= '0;
			rate_q        <= '0;
			kick_timer_q  <= '0;
			kick_active_q <= 1'b0;
			fade_length_q <= frkc_pkg::DEFAULT_LENGTH;
			out_valid_q   <= 1'b0;
			div_cnt_q     <= '0;
		end else begin
			// result register: load on the final step, clear once taken
			if ((state_q == ST_DONE) && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (mode) begin
							fade_length_q <= len_eff;
							div_dvs_q     <= len_eff;
							div_quo_q     <= frkc_pkg::LEVEL_FULL;
							div_rem_q     <= '0;
							div_cnt_q     <= '0;
							fin_q         <= fade_in;
							state_q       <= ST_RATE_DIV;
						end else begin
							delta_q <= delta_ms;
							state_q <= ST_MUL;
						end
					end
				end
				ST_RATE_DIV: begin
					div_quo_q <= quo_nx;
					div_rem_q <= rem_nx;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_last) begin
						rate_q <= fin_q ? rate_mag : -rate_mag;
						if (fin_q) begin
							kick_timer_q  <= '0;
							kick_active_q <= 1'b1;
						end
						state_q <= ST_CURVE_SETUP;
					end
				end
				ST_MUL: begin
					prod_q  <= PROD_W'(rate_q * $signed({1'b0, delta_q}));
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (rate_q != '0) begin
						if (level_sum < 0) begin
							level_q <= '0;
							rate_q  <= '0;
						end else if (level_sum > $signed(SUM_W'(frkc_pkg::LEVEL_FULL))) begin
							level_q <= frkc_pkg::LEVEL_FULL;
							rate_q  <= '0;
						end else begin
							level_q <= level_sum[frkc_pkg::LEVEL_W-1:0];
						end
					end
					if (kick_active_q) begin
						if (timer_sum > {1'b0, fade_length_q}) begin
							kick_active_q <= 1'b0;
							kick_timer_q  <= '0;
						end else begin
							kick_timer_q <= timer_sum[frkc_pkg::TIME_W-1:0];
						end
					end
					state_q <= ST_CURVE_SETUP;
				end
				ST_CURVE_SETUP: begin
					if (kick_active_q) begin
						div_quo_q <= frkc_pkg::DIV_N_W'({timer_clamped,
							{frkc_pkg::CURVE_SHIFT{1'b0}}});
						div_rem_q <= '0;
						div_dvs_q <= fade_length_q;
						div_cnt_q <= '0;
						state_q   <= ST_CURVE_DIV;
					end else begin
						kick_idx_q <= '0;
						state_q    <= ST_DONE;
					end
				end
				ST_CURVE_DIV: begin
					div_quo_q <= quo_nx;
					div_rem_q <= rem_nx;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_last) begin
						kick_idx_q <= quo_nx[frkc_pkg::CURVE_IDX_W-1:0];
						state_q    <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						fader_level_q   <= level_q;
						kick_in_level_q <= kick_active_q ? frkc_pkg::CURVE_ROM[kick_idx_q] : '0;
						fader_idle_q    <= (level_q == '0) && (rate_q == '0);
						kick_in_idle_q  <= !kick_active_q || (kick_timer_q == '0);
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready      = state_q == ST_IDLE;
	assign out_valid     = out_valid_q;
	assign fader_level   = fader_level_q;
	assign kick_in_level = kick_in_level_q;
	assign fader_idle    = fader_idle_q;
	assign kick_in_idle  = kick_in_idle_q;

	// level never leaves [0, 1.0]
	`FRKC_ASSERT_IMPL(a_level_range, clk, arst_n, 1'b1, level_q <= frkc_pkg::LEVEL_FULL)
	// an inactive kick-in timer always reads zero
	`FRKC_ASSERT_IMPL(a_timer_clear, clk, arst_n, !kick_active_q, kick_timer_q == '0)
	// the divider never runs against a zero divisor
	`FRKC_ASSERT_IMPL(a_div_nonzero, clk, arst_n,
		(state_q == ST_RATE_DIV) || (state_q == ST_CURVE_DIV), div_dvs_q != '0)
	// a result is presented right after the final step when the output is free
	`FRKC_ASSERT_NEXT(a_done_emits, clk, arst_n, (state_q == ST_DONE) && out_free,
		out_valid_q && (state_q == ST_IDLE))

endmodule

`default_nettype wire

// ===== tb/fade_ramp_with_kick_in_curve_test.sv =====
`timescale 1ns / 1ps

module fade_ramp_with_kick_in_curve_test;

	localparam int unsigned TIME_W  = frkc_pkg::TIME_W;
	localparam int unsigned LEVEL_W = frkc_pkg::LEVEL_W;
	localparam int unsigned KICK_W  = frkc_pkg::KICK_W;

	// item codes
	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_START = 1'b1;
	localparam logic FADE_OUT   = 1'b0;
	localparam logic FADE_IN    = 1'b1;

	// fixed-point constants of the curve
	localparam int unsigned     FRAC_Q      = 30;
	localparam longint unsigned ONE_Q30     = 64'd1 << FRAC_Q;
	localparam longint unsigned PI_FIXED    = 64'd3373259426;
	localparam longint          LEVEL_ONE   = longint'(1) << frkc_pkg::LEVEL_FRAC_BITS;
	localparam int unsigned     CURVE_STEPS = frkc_pkg::CURVE_POINTS;
	localparam int unsigned     CURVE_IDX_W = frkc_pkg::CURVE_IDX_W;

	// run shape
	localparam int unsigned ITEM_TARGET  = 1150;
	localparam int unsigned PHASE_ONE    = 400;
	localparam int unsigned PHASE_TWO    = 800;
	localparam int unsigned HOLD_AT      = 200;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 80;
	localparam int unsigned CYCLE_LIMIT  = 1000000;

	typedef struct {
		logic              mode;
		logic [TIME_W-1:0] delta_ms;
		logic              fade_in;
		logic [TIME_W-1:0] fade_length_ms;
	} fade_cmd_t;

	typedef struct {
		logic [LEVEL_W-1:0] fader_level;
		logic [KICK_W-1:0]  kick_in_level;
		logic               fader_idle;
		logic               kick_in_idle;
	} fade_out_t;

	// dut signals; the driven inputs are known from time zero
	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               in_valid       = 1'b0;
	logic               in_ready;
	logic               mode           = MODE_TICK;
	logic [TIME_W-1:0]  delta_ms       = '0;
	logic               fade_in        = FADE_OUT;
	logic [TIME_W-1:0]  fade_length_ms = '0;
	logic               out_valid;
	logic               out_ready      = 1'b0;
	logic [LEVEL_W-1:0] fader_level;
	logic [KICK_W-1:0]  kick_in_level;
	logic               fader_idle;
	logic               kick_in_idle;

	// fader state as the block should hold it
	longint          fade_level   = 0;
	longint          fade_rate    = 0;
	longint unsigned kick_time    = 0;
	logic            kick_running = 1'b0;
	longint unsigned fade_len_ms  = frkc_pkg::DEFAULT_LENGTH;

	logic [KICK_W-1:0] kick_curve [0:CURVE_STEPS];

	fade_cmd_t   fade_commands[$];
	fade_out_t   expected_levels[$];
	int unsigned total_items  = 0;
	int unsigned items_taken  = 0;
	int unsigned mismatches   = 0;
	int unsigned hold_left    = 0;
	logic        hold_done    = 1'b0;
	int unsigned cycle_count  = 0;

	fade_ramp_with_kick_in_curve u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.delta_ms       (delta_ms),
		.fade_in        (fade_in),
		.fade_length_ms (fade_length_ms),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.fader_level    (fader_level),
		.kick_in_level  (kick_in_level),
		.fader_idle     (fader_idle),
		.kick_in_idle   (kick_in_idle)
	);

	always #5 clk = ~clk;

	// floor square root, two bits per step
	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned bitv;
		longint unsigned rem;
		root = 0;
		bitv = 64'd1 << 62;
		rem  = v;
		while (bitv > rem) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem  = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// log2 in Q30: integer part plus fraction from repeated squaring
	function automatic longint unsigned log2_fixed(input longint unsigned v);
		int unsigned     whole;
		longint unsigned m;
		longint unsigned frac;
		int              k;
		whole = 0;
		frac  = 0;
		while ((v >> whole) > 1 && whole < FRAC_Q) whole++;
		m = v << (FRAC_Q - whole);
		for (k = 1; k <= FRAC_Q; k++) begin
			m = (m * m) >> FRAC_Q;
			if (m >= 2 * ONE_Q30) begin
				m    = m >> 1;
				frac = frac | (64'd1 << (FRAC_Q - k));
			end
		end
		return (64'(whole) << FRAC_Q) | frac;
	endfunction

	// sin^3(pi * x^0.66) for x = idx / CURVE_STEPS, scaled to 65535
	function automatic logic [KICK_W-1:0] kick_curve_point(input int unsigned idx);
		longint unsigned log_gap, expo, ipart, fpart, prod, root2, u, w, ang;
		longint unsigned term, den, s, s3, scaled;
		longint          sum;
		int              k;
		int              n;
		if (idx == 0 || idx > CURVE_STEPS) return '0;
		log_gap = log2_fixed(CURVE_STEPS);
		expo    = log2_fixed(idx);
		log_gap = (log_gap > expo) ? log_gap - expo : 64'd0;
		expo    = log_gap * 66 / 100;
		ipart = expo >> FRAC_Q;
		fpart = expo & (ONE_Q30 - 1);
		// 2^-frac as a product of 2^(-2^-k) factors
		prod  = ONE_Q30;
		root2 = ONE_Q30 / 2;
		for (k = 1; k <= FRAC_Q; k++) begin
			root2 = floor_sqrt(root2 << FRAC_Q);
			if (((fpart >> (FRAC_Q - k)) & 64'd1) != 0) prod = (prod * root2) >> FRAC_Q;
		end
		u = (ipart >= 63) ? 64'd0 : prod >> ipart;
		if (u > ONE_Q30) u = ONE_Q30;
		w   = (ONE_Q30 - u < u) ? ONE_Q30 - u : u;
		ang = (w * PI_FIXED) >> FRAC_Q;
		// taylor sine up to the 15th power
		term = ang;
		sum  = longint'(ang);
		for (n = 1; n <= 7; n++) begin
			term = (term * ang) >> FRAC_Q;
			term = (term * ang) >> FRAC_Q;
			den  = 64'((2 * n) * (2 * n + 1));
			term = term / den;
			if ((n & 1) != 0) sum = sum - longint'(term);
			else              sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		s = longint'(sum);
		if (s > ONE_Q30) s = ONE_Q30;
		s3     = (((s * s) >> FRAC_Q) * s) >> FRAC_Q;
		scaled = (s3 * 65535 + ONE_Q30 / 2) >> FRAC_Q;
		return (scaled > 65535) ? {KICK_W{1'b1}} : scaled[KICK_W-1:0];
	endfunction

	// apply one accepted transaction to the fader state and store its result
	task automatic advance_fader(input logic m, input logic [TIME_W-1:0] dt,
			input logic fin, input logic [TIME_W-1:0] len_in);
		longint          step_ms;
		longint          mag;
		longint unsigned t_new;
		longint unsigned t_clamped;
		longint unsigned idx;
		fade_out_t       res;
		step_ms = dt;
		if (m == MODE_START) begin
			fade_len_ms = (len_in == 0) ? 64'd1 : 64'(len_in);
			mag         = LEVEL_ONE / longint'(fade_len_ms);
			fade_rate   = (fin == FADE_IN) ? mag : -mag;
			if (fin == FADE_IN) begin
				kick_time    = 0;
				kick_running = 1'b1;
			end
		end else begin
			// ramp stops only when the level would leave 0..1
			if (fade_rate != 0) begin
				fade_level = fade_level + fade_rate * step_ms;
				if (fade_level < 0) begin
					fade_level = 0;
					fade_rate  = 0;
				end else if (fade_level > LEVEL_ONE) begin
					fade_level = LEVEL_ONE;
					fade_rate  = 0;
				end
			end
			if (kick_running) begin
				t_new = kick_time + longint'(step_ms);
				if (t_new > fade_len_ms) begin
					kick_running = 1'b0;
					kick_time    = 0;
				end else begin
					kick_time = t_new;
				end
			end
		end
		res.kick_in_level = '0;
		if (kick_running) begin
			t_clamped         = (kick_time > fade_len_ms) ? fade_len_ms : kick_time;
			idx               = t_clamped * CURVE_STEPS / fade_len_ms;
			res.kick_in_level = kick_curve[CURVE_IDX_W'(idx)];
		end
		res.fader_level  = fade_level[LEVEL_W-1:0];
		res.fader_idle   = (fade_level == 0 && fade_rate == 0);
		res.kick_in_idle = (!kick_running || kick_time == 0);
		expected_levels.push_back(res);
	endtask

	task automatic queue_cmd(input logic m, input int unsigned d, input logic f,
			input int unsigned l);
		fade_cmd_t cmd;
		cmd.mode           = m;
		cmd.delta_ms       = d[TIME_W-1:0];
		cmd.fade_in        = f;
		cmd.fade_length_ms = l[TIME_W-1:0];
		fade_commands.push_back(cmd);
	endtask

	// driver: offers the queued transactions, idling at random by phase
	always @(posedge clk) begin : drive_proc
		int unsigned send_idle;
		fade_cmd_t   cmd;
		if (arst_n) begin
			send_idle = (items_taken < PHASE_ONE) ? 16 : (items_taken < PHASE_TWO) ? 59 : 0;
			if (in_valid && in_ready) begin
				advance_fader(mode, delta_ms, fade_in, fade_length_ms);
				items_taken <= items_taken + 1;
			end
			if (!in_valid || in_ready) begin
				if (fade_commands.size() != 0 && $urandom_range(99) >= send_idle) begin
					cmd = fade_commands.pop_front();
					in_valid       <= 1'b1;
					mode           <= cmd.mode;
					delta_ms       <= cmd.delta_ms;
					fade_in        <= cmd.fade_in;
					fade_length_ms <= cmd.fade_length_ms;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// one long output hold-off while the sender keeps offering
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && items_taken >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end
	end

	// monitor: checks each result transaction against the oldest expectation
	always @(posedge clk) begin : watch_proc
		int unsigned recv_idle;
		fade_out_t   want;
		if (arst_n) begin
			recv_idle = (items_taken < PHASE_ONE) ? 59 : (items_taken < PHASE_TWO) ? 16 : 0;
			if (out_valid && out_ready) begin
				if (expected_levels.size() == 0) begin
					$error("result transaction with nothing expected");
					mismatches++;
				end else begin
					want = expected_levels.pop_front();
					if (fader_level !== want.fader_level) begin
						$error("fader_level: expected %0d, got %0d", want.fader_level,
							fader_level);
						mismatches++;
					end
					if (kick_in_level !== want.kick_in_level) begin
						$error("kick_in_level: expected %0d, got %0d", want.kick_in_level,
							kick_in_level);
						mismatches++;
					end
					if (fader_idle !== want.fader_idle) begin
						$error("fader_idle: expected %0d, got %0d", want.fader_idle,
							fader_idle);
						mismatches++;
					end
					if (kick_in_idle !== want.kick_in_idle) begin
						$error("kick_in_idle: expected %0d, got %0d", want.kick_in_idle,
							kick_in_idle);
						mismatches++;
					end
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
		end
	end

	// timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : main_proc
		int unsigned idx;
		int unsigned len;
		int unsigned nticks;
		int unsigned sel;
		int unsigned t;
		logic        fin;

		for (idx = 0; idx <= CURVE_STEPS; idx++) begin
			kick_curve[CURVE_IDX_W'(idx)] = kick_curve_point(idx);
		end

		// directed: idle ticks with ignored fields set
		queue_cmd(MODE_TICK, 0, FADE_OUT, 0);
		queue_cmd(MODE_TICK, 65535, FADE_IN, 65535);
		// zero length becomes 1 ms; level lands exactly on full, then overshoots
		queue_cmd(MODE_START, 65535, FADE_IN, 0);
		queue_cmd(MODE_TICK, 0, FADE_OUT, 0);
		queue_cmd(MODE_TICK, 1, FADE_OUT, 0);
		queue_cmd(MODE_TICK, 1, FADE_OUT, 0);
		// slowest fade-out: lands exactly on zero, ramp still running, then clamps
		queue_cmd(MODE_START, 0, FADE_OUT, 65535);
		queue_cmd(MODE_TICK, 65535, FADE_OUT, 0);
		queue_cmd(MODE_TICK, 1, FADE_OUT, 0);
		queue_cmd(MODE_TICK, 1, FADE_OUT, 0);
		// kick-in walk, then a shorter fade-out while the timer runs
		queue_cmd(MODE_START, 0, FADE_IN, 3000);
		queue_cmd(MODE_TICK, 1, FADE_OUT, 0);
		queue_cmd(MODE_TICK, 100, FADE_OUT, 0);
		queue_cmd(MODE_TICK, 1000, FADE_OUT, 0);
		queue_cmd(MODE_START, 0, FADE_OUT, 500);
		queue_cmd(MODE_TICK, 0, FADE_OUT, 0);
		queue_cmd(MODE_TICK, 10, FADE_OUT, 0);
		// timer reaching the longest length exactly, then overrun
		queue_cmd(MODE_START, 0, FADE_IN, 65535);
		queue_cmd(MODE_TICK, 65535, FADE_OUT, 0);
		queue_cmd(MODE_TICK, 1, FADE_OUT, 0);
		// steepest ramps with the largest step
		queue_cmd(MODE_START, 0, FADE_IN, 1);
		queue_cmd(MODE_TICK, 65535, FADE_OUT, 0);
		queue_cmd(MODE_START, 0, FADE_OUT, 1);
		queue_cmd(MODE_TICK, 65535, FADE_OUT, 0);

		// random: mostly a start followed by ticks scaled to its length
		while (fade_commands.size() < ITEM_TARGET) begin
			if ($urandom_range(99) < 85) begin
				sel = $urandom_range(19);
				if (sel == 0)      len = 0;
				else if (sel == 1) len = 65535;
				else if (sel == 2) len = $urandom_range(65535);
				else               len = $urandom_range(3000, 1);
				fin = ($urandom_range(99) < 70) ? FADE_IN : FADE_OUT;
				queue_cmd(MODE_START, $urandom, fin, len);
				nticks = $urandom_range(12, 1);
				for (t = 0; t < nticks; t++) begin
					if ($urandom_range(14) == 0) begin
						queue_cmd(MODE_START, $urandom, FADE_OUT, $urandom_range(3000));
					end else if ($urandom_range(9) == 0) begin
						queue_cmd(MODE_TICK, $urandom, 1'($urandom), $urandom);
					end else begin
						queue_cmd(MODE_TICK, $urandom_range(len / 6 + 1), 1'($urandom),
							$urandom);
					end
				end
			end else begin
				queue_cmd(1'($urandom), $urandom, 1'($urandom), $urandom);
			end
		end
		total_items = fade_commands.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (items_taken != total_items || expected_levels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
